// ===== hdl/ipmpb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ipmpb_pkg;

    localparam int SCREEN_WIDTH_DEF  = 256;
    localparam int SCREEN_HEIGHT_DEF = 64;
    localparam int PANEL_WIDTH_DEF   = 128;
    localparam int PALETTE_SIZE_DEF  = 256;

    // widest store address over the parameter range: 2 panels * 256 cols * 16 pages
    localparam int STORE_ADDR_W = 13;

    localparam int QUEUE_DEPTH = 2;

    localparam int S_DATA_W = 80;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 16;

    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_DRAW = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_LOAD = 2'd1,
        OP_DRAW = 2'd2,
        OP_READ = 2'd3
    } op_kind_t;

    typedef struct packed {
        op_kind_t                  kind;
        logic [7:0]                pal_addr;
        logic                      pal_bit;
        logic                      code_ok;
        logic [STORE_ADDR_W-1:0]   store_addr;
        logic [2:0]                bit_sel;
    } op_t;

    function automatic logic rgb565_to_mono(input logic [15:0] color);
        logic [6:0] rgb_sum;
        logic [9:0] scaled;
        rgb_sum = 7'(color[15:11]) + 7'(color[10:5]) + 7'(color[4:0]);
        scaled  = {rgb_sum, 3'b000};
        return scaled[9];
    endfunction

endpackage

`default_nettype wire

// ===== hdl/indexed_pixel_to_mono_page_buffer_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  handshake          payload
// s_        in   s_tvalid/s_tready  s_tuser command, s_tdata draw/load/read fields
// m_        out  m_tvalid/m_tready  m_tdata read_data, pixel_written
//
// One request per cycle sustained while m_tready is high and no clearing pass runs;
// m_tvalid is registered behind the queue entry written at the input accept edge,
// then the memory read, then the result register. The store and palette memories
// each give one read and one write a cycle; the store read returns a registered
// byte, the palette read a bit, each patched by forwarding from the last write.
// After reset a clearing pass zeroes both memories, one entry a cycle, with s_tready
// low. A stalled m_tready backs up through the queue to s_tready.
module indexed_pixel_to_mono_page_buffer_core #(
    parameter int SCREEN_WIDTH  = ipmpb_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = ipmpb_pkg::SCREEN_HEIGHT_DEF,
    parameter int PANEL_WIDTH   = ipmpb_pkg::PANEL_WIDTH_DEF,
    parameter int PALETTE_SIZE  = ipmpb_pkg::PALETTE_SIZE_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // palette_slot, palette_color, pixel_code, pos_x, pos_y, transparent_code,
    // background_code, restore_background, use_transparency, read_display,
    // read_offset, zero pad
    input  wire logic [ipmpb_pkg::S_DATA_W-1:0] s_tdata,
    // command
    input  wire logic [ipmpb_pkg::S_USER_W-1:0] s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // read_data, pixel_written, zero pad
    output logic [ipmpb_pkg::M_DATA_W-1:0]      m_tdata
);

    ipmpb_pkg::op_t front_op;
    ipmpb_pkg::op_t head_op;
    logic           q_ready;
    logic           q_valid;
    logic           q_pop;
    logic           busy;
    logic           push;

    assign s_tready = q_ready && !busy;
    assign push     = s_tvalid && s_tready;

    ipmpb_front #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .PANEL_WIDTH   (PANEL_WIDTH),
        .PALETTE_SIZE  (PALETTE_SIZE)
    ) u_front (
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .op      (front_op)
    );

    ipmpb_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (front_op),
        .ready   (q_ready),
        .valid   (q_valid),
        .head_op (head_op),
        .pop     (q_pop)
    );

    ipmpb_back #(
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .PANEL_WIDTH   (PANEL_WIDTH),
        .PALETTE_SIZE  (PALETTE_SIZE)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .busy     (busy),
        .q_valid  (q_valid),
        .q_op     (head_op),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

// ===== hdl/ipmpb_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ipmpb_front #(
    parameter int SCREEN_WIDTH  = ipmpb_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = ipmpb_pkg::SCREEN_HEIGHT_DEF,
    parameter int PANEL_WIDTH   = ipmpb_pkg::PANEL_WIDTH_DEF,
    parameter int PALETTE_SIZE  = ipmpb_pkg::PALETTE_SIZE_DEF
) (
    input  wire logic [ipmpb_pkg::S_DATA_W-1:0] s_tdata,
    input  wire logic [ipmpb_pkg::S_USER_W-1:0] s_tuser,
    output ipmpb_pkg::op_t                      op
);

    localparam int PAGE_COUNT  = (SCREEN_HEIGHT + 7) / 8;
    localparam int PANEL_BYTES = PANEL_WIDTH * PAGE_COUNT;

    localparam logic [9:0]  SW_LIM  = 10'(SCREEN_WIDTH);
    localparam logic [9:0]  PW_LIM  = 10'(PANEL_WIDTH);
    localparam logic [7:0]  SH_LIM  = 8'(SCREEN_HEIGHT);
    localparam logic [8:0]  PAL_LIM = 9'(PALETTE_SIZE);
    localparam logic [15:0] PB_16   = 16'(PANEL_BYTES);
    localparam logic [15:0] PW_16   = 16'(PANEL_WIDTH);

    logic [7:0]  slot;
    logic [15:0] color;
    logic [7:0]  code;
    logic [8:0]  pos_x;
    logic [5:0]  pos_y;
    logic [7:0]  transp;
    logic [7:0]  backgr;
    logic        restore;
    logic        use_tr;
    logic        rdisp;
    logic [9:0]  roff;

    logic [7:0]  code_eff;
    logic        skip;
    logic [9:0]  x10;
    logic        left;
    logic [9:0]  col10;
    logic        draw_ok;
    logic [15:0] draw_addr;
    logic [15:0] read_addr;
    logic        read_ok;
    logic        slot_ok;

    assign slot    = s_tdata[7:0];
    assign color   = s_tdata[23:8];
    assign code    = s_tdata[31:24];
    assign pos_x   = s_tdata[40:32];
    assign pos_y   = s_tdata[46:41];
    assign transp  = s_tdata[54:47];
    assign backgr  = s_tdata[62:55];
    assign restore = s_tdata[63];
    assign use_tr  = s_tdata[64];
    assign rdisp   = s_tdata[65];
    assign roff    = s_tdata[75:66];

    always_comb
    begin
        code_eff = (restore && code == transp) ? backgr : code;
        skip     = !restore && use_tr && code == transp;
        x10      = {1'b0, pos_x};
        left     = x10 < PW_LIM;
        col10    = left ? x10 : x10 - PW_LIM;
        draw_ok  = !skip && (x10 < SW_LIM) && (col10 < PW_LIM) && ({2'b00, pos_y} < SH_LIM);
        draw_addr = (left ? 16'd0 : PB_16) + 16'(pos_y[5:3]) * PW_16 + {6'd0, col10};
        read_ok   = {6'd0, roff} < PB_16;
        read_addr = (rdisp ? PB_16 : 16'd0) + {6'd0, roff};
        slot_ok   = {1'b0, slot} < PAL_LIM;

        op.pal_bit  = ipmpb_pkg::rgb565_to_mono(color);
        op.code_ok  = {1'b0, code_eff} < PAL_LIM;
        op.bit_sel  = pos_y[2:0];
        op.pal_addr = code_eff;
        op.store_addr = draw_addr[ipmpb_pkg::STORE_ADDR_W-1:0];
        op.kind     = ipmpb_pkg::OP_NONE;

        unique case (s_tuser)
            ipmpb_pkg::CMD_LOAD:
            begin
                op.pal_addr = slot;
                if (slot_ok)
                    op.kind = ipmpb_pkg::OP_LOAD;
            end
            ipmpb_pkg::CMD_DRAW:
            begin
                if (draw_ok)
                    op.kind = ipmpb_pkg::OP_DRAW;
            end
            ipmpb_pkg::CMD_READ:
            begin
                op.store_addr = read_addr[ipmpb_pkg::STORE_ADDR_W-1:0];
                if (read_ok)
                    op.kind = ipmpb_pkg::OP_READ;
            end
            default:
            begin
                op.kind = ipmpb_pkg::OP_NONE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/ipmpb_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ipmpb_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire ipmpb_pkg::op_t push_op,
    output logic                ready,
    output logic                valid,
    output ipmpb_pkg::op_t      head_op,
    input  wire logic           pop
);

    localparam int DEPTH = ipmpb_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    ipmpb_pkg::op_t   entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign ready   = count_reg != CNT_FULL;
    assign valid   = count_reg != '0;
    assign head_op = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_op;
    end

endmodule

`default_nettype wire

// ===== hdl/ipmpb_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ipmpb_back #(
    parameter int SCREEN_HEIGHT = ipmpb_pkg::SCREEN_HEIGHT_DEF,
    parameter int PANEL_WIDTH   = ipmpb_pkg::PANEL_WIDTH_DEF,
    parameter int PALETTE_SIZE  = ipmpb_pkg::PALETTE_SIZE_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    output logic                                busy,
    input  wire logic                           q_valid,
    input  wire ipmpb_pkg::op_t                 q_op,
    output logic                                q_pop,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [ipmpb_pkg::M_DATA_W-1:0]      m_tdata
);

    localparam int PAGE_COUNT  = (SCREEN_HEIGHT + 7) / 8;
    localparam int PANEL_BYTES = PANEL_WIDTH * PAGE_COUNT;
    localparam int STORE_DEPTH = 2 * PANEL_BYTES;
    localparam int SA_W        = $clog2(STORE_DEPTH);
    localparam int PAL_AW      = $clog2(PALETTE_SIZE);
    localparam int CLR_DEPTH   = (STORE_DEPTH > PALETTE_SIZE) ? STORE_DEPTH : PALETTE_SIZE;
    localparam int CLR_W       = $clog2(CLR_DEPTH);
    localparam logic [CLR_W-1:0] CLR_LAST  = CLR_W'(CLR_DEPTH - 1);
    localparam logic [CLR_W:0]   CLR_ST    = (CLR_W + 1)'(STORE_DEPTH);
    localparam logic [CLR_W:0]   CLR_PAL   = (CLR_W + 1)'(PALETTE_SIZE);

    logic [7:0]        store_mem [STORE_DEPTH];
    logic              pal_mem   [PALETTE_SIZE];

    logic              clearing_reg;
    logic [CLR_W-1:0]  clr_cnt_reg;

    logic              b1_valid_reg;
    ipmpb_pkg::op_t    b1_op_reg;
    logic [7:0]        store_rd_reg;
    logic              pal_rd_reg;

    logic              fwd_st_valid_reg;
    logic [SA_W-1:0]   fwd_st_addr_reg;
    logic [7:0]        fwd_st_data_reg;
    logic              fwd_pal_valid_reg;
    logic [PAL_AW-1:0] fwd_pal_addr_reg;
    logic              fwd_pal_data_reg;

    logic              out_valid_reg;
    logic [7:0]        out_data_reg;
    logic              out_written_reg;

    logic              b1_fire;
    logic              issue;
    logic [SA_W-1:0]   b1_st_addr;
    logic [PAL_AW-1:0] b1_pal_addr;
    logic [7:0]        cur_byte;
    logic              cur_bit;
    logic [7:0]        mask;
    logic [7:0]        new_byte;
    logic              st_we;
    logic [SA_W-1:0]   st_waddr;
    logic [7:0]        st_wdata;
    logic              pal_we;
    logic [PAL_AW-1:0] pal_waddr;
    logic              pal_wdata;
    logic              do_draw;
    logic              do_load;

    assign busy     = clearing_reg;
    assign b1_fire  = b1_valid_reg && (!out_valid_reg || m_tready);
    assign issue    = q_valid && !clearing_reg && (!b1_valid_reg || b1_fire);
    assign q_pop    = issue;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_written_reg, out_data_reg};

    assign b1_st_addr  = b1_op_reg.store_addr[SA_W-1:0];
    assign b1_pal_addr = b1_op_reg.pal_addr[PAL_AW-1:0];
    assign do_draw     = b1_fire && b1_op_reg.kind == ipmpb_pkg::OP_DRAW;
    assign do_load     = b1_fire && b1_op_reg.kind == ipmpb_pkg::OP_LOAD;

    // forward the most recent write over the registered read
    always_comb
    begin
        cur_byte = (fwd_st_valid_reg && fwd_st_addr_reg == b1_st_addr)
                   ? fwd_st_data_reg : store_rd_reg;
        cur_bit  = (fwd_pal_valid_reg && fwd_pal_addr_reg == b1_pal_addr)
                   ? fwd_pal_data_reg : pal_rd_reg;
        if (!b1_op_reg.code_ok)
            cur_bit = 1'b0;
        mask     = 8'd1 << b1_op_reg.bit_sel;
        new_byte = cur_bit ? (cur_byte | mask) : (cur_byte & ~mask);
    end

    always_comb
    begin
        if (clearing_reg)
        begin
            st_we     = {1'b0, clr_cnt_reg} < CLR_ST;
            st_waddr  = clr_cnt_reg[SA_W-1:0];
            st_wdata  = 8'd0;
            pal_we    = {1'b0, clr_cnt_reg} < CLR_PAL;
            pal_waddr = clr_cnt_reg[PAL_AW-1:0];
            pal_wdata = 1'b0;
        end
        else
        begin
            st_we     = do_draw;
            st_waddr  = b1_st_addr;
            st_wdata  = new_byte;
            pal_we    = do_load;
            pal_waddr = b1_pal_addr;
            pal_wdata = b1_op_reg.pal_bit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_we)
            store_mem[st_waddr] <= st_wdata;
        if (issue)
            store_rd_reg <= store_mem[q_op.store_addr[SA_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (pal_we)
            pal_mem[pal_waddr] <= pal_wdata;
        if (issue)
            pal_rd_reg <= pal_mem[q_op.pal_addr[PAL_AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (issue)
            b1_op_reg <= q_op;
        if (do_draw)
        begin
            fwd_st_addr_reg <= b1_st_addr;
            fwd_st_data_reg <= new_byte;
        end
        if (do_load)
        begin
            fwd_pal_addr_reg <= b1_pal_addr;
            fwd_pal_data_reg <= b1_op_reg.pal_bit;
        end
        if (b1_fire)
        begin
            out_data_reg    <= (b1_op_reg.kind == ipmpb_pkg::OP_READ) ? cur_byte : 8'd0;
            out_written_reg <= b1_op_reg.kind == ipmpb_pkg::OP_DRAW;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg      <= 1'b1;
            clr_cnt_reg       <= '0;
            b1_valid_reg      <= 1'b0;
            fwd_st_valid_reg  <= 1'b0;
            fwd_pal_valid_reg <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (clearing_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == CLR_LAST)
                    clearing_reg <= 1'b0;
            end
            if (issue)
                b1_valid_reg <= 1'b1;
            else if (b1_fire)
                b1_valid_reg <= 1'b0;
            if (do_draw)
                fwd_st_valid_reg <= 1'b1;
            if (do_load)
                fwd_pal_valid_reg <= 1'b1;
            if (b1_fire)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

endmodule

`default_nettype wire
